@@ rtl/edet_pkg.sv @@
// types and constants shared by the earliest-due entry table
`timescale 1ns / 1ps

package edet_pkg;

    // widths sized for the largest table this block supports
    localparam int MAX_CAPACITY = 32;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 6;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_FIND   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // one stored entry; dose = {quantity, slot, doses per day, units per dose}
    typedef struct packed {
        logic [15:0] id;
        logic [30:0] date;
        logic [16:0] time_s;
        logic [27:0] dose;
    } entry_t;

    // operation word travelling down the row of cells
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic             act;
        logic [15:0]      id;
        logic [30:0]      date;
        logic [16:0]      time_s;
        logic [27:0]      dose;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] sel;
        logic             found;
        logic [IDX_W-1:0] k;
        logic             have_best;
        logic [30:0]      best_date;
        logic [16:0]      best_time;
        logic [IDX_W-1:0] best_idx;
        logic [15:0]      best_id;
        logic [3:0]       best_slot;
        logic [30:0]      sel_date;
        logic [16:0]      sel_time;
        logic [15:0]      sel_id;
        logic [3:0]       sel_slot;
    } pkt_t;

    // gap-closing command after a delete
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] k;
    } shift_t;

endpackage

@@ rtl/edet_cell.sv @@
// one table cell: holds an entry and passes the operation word to its neighbour
`timescale 1ns / 1ps

module edet_cell
    import edet_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CAPACITY = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  pkt_t   pkt_in,
    input  shift_t shift_cmd,
    input  entry_t nxt_entry,
    output entry_t entry,
    output pkt_t   pkt_out
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(CELL_IDX);
    localparam bit               HAS_NEXT = (CELL_IDX + 1) < CAPACITY;

    entry_t ent_reg;
    pkt_t   pkt_reg;
    pkt_t   pkt_next;
    logic   wr_en;
    logic   wr_id;
    logic   in_range;

    assign entry   = ent_reg;
    assign pkt_out = pkt_reg;

    // per-cell action on the passing word
    always_comb
    begin
        pkt_next = pkt_in;
        wr_en    = 1'b0;
        wr_id    = 1'b0;
        in_range = MY_CNT < pkt_in.cnt;
        if (pkt_in.valid && pkt_in.act)
        begin
            case (pkt_in.kind)
                KIND_ADD:
                begin
                    if (MY_CNT == pkt_in.cnt)
                    begin
                        wr_en = 1'b1;
                        wr_id = 1'b1;
                    end
                end
                KIND_UPDATE:
                begin
                    if (in_range && !pkt_in.found && ent_reg.id == pkt_in.id)
                    begin
                        wr_en          = 1'b1;
                        pkt_next.found = 1'b1;
                        pkt_next.k     = MY_IDX;
                    end
                end
                KIND_DELETE:
                begin
                    if (in_range && !pkt_in.found && ent_reg.id == pkt_in.id)
                    begin
                        pkt_next.found = 1'b1;
                        pkt_next.k     = MY_IDX;
                    end
                end
                KIND_FIND:
                begin
                    if (in_range)
                    begin
                        if (MY_IDX == pkt_in.sel)
                        begin
                            pkt_next.sel_date = ent_reg.date;
                            pkt_next.sel_time = ent_reg.time_s;
                            pkt_next.sel_id   = ent_reg.id;
                            pkt_next.sel_slot = ent_reg.dose[11:8];
                        end
                        if (!pkt_in.have_best ||
                            {ent_reg.date, ent_reg.time_s} <
                            {pkt_in.best_date, pkt_in.best_time})
                        begin
                            pkt_next.have_best = 1'b1;
                            pkt_next.best_date = ent_reg.date;
                            pkt_next.best_time = ent_reg.time_s;
                            pkt_next.best_idx  = MY_IDX;
                            pkt_next.best_id   = ent_reg.id;
                            pkt_next.best_slot = ent_reg.dose[11:8];
                        end
                    end
                end
                default:
                begin
                    pkt_next = pkt_in;
                end
            endcase
        end
    end

    // entry storage: write from the word, or take the neighbour's entry
    always_ff @(posedge clk)
    begin
        if (shift_cmd.valid && HAS_NEXT && MY_IDX >= shift_cmd.k)
        begin
            ent_reg <= nxt_entry;
        end
        else if (wr_en)
        begin
            if (wr_id)
            begin
                ent_reg.id <= pkt_in.id;
            end
            ent_reg.date   <= pkt_in.date;
            ent_reg.time_s <= pkt_in.time_s;
            ent_reg.dose   <= pkt_in.dose;
        end
    end

    // operation word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

endmodule

@@ rtl/earliest_due_entry_table_top.sv @@
// earliest-due entry table: top level with control and the row of cells
//
//  channel | direction | fields
//  --------+-----------+------------------------------------------------------
//  in      | in        | kind entry_id due_date due_time remaining_quantity
//          |           | storage_slot doses_per_day units_per_dose
//  out     | out       | status entry_count earliest_index earliest_id
//          |           | earliest_slot
//
//  one word at a time: a word walks the row of CAPACITY cells, one cell a cycle,
//  then its result goes to a hold register and, for a delete that hits, through
//  a gap-closing shift, before it moves to the output register. the next word is
//  taken as soon as the result has moved to the output register, even if it is
//  not yet taken.
//  reset clears count, selection and handshake state; entries are undefined.
//  a stalled output holds its word and blocks only the following result.
`timescale 1ns / 1ps

module earliest_due_entry_table_top
    import edet_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] entry_id,
    input  logic [30:0] due_date,
    input  logic [16:0] due_time,
    input  logic [15:0] remaining_quantity,
    input  logic [3:0]  storage_slot,
    input  logic [3:0]  doses_per_day,
    input  logic [3:0]  units_per_dose,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  entry_count,
    output logic [2:0]  earliest_index,
    output logic [15:0] earliest_id,
    output logic [3:0]  earliest_slot
);

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
        logic [15:0]      id;
        logic [3:0]       slot;
    } res_t;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] sel_reg;
    pkt_t             launch_reg;
    pkt_t             launch_next;
    pkt_t             pkt_chain [0:CAPACITY];
    entry_t           ents      [0:CAPACITY-1];
    entry_t           nxt_ents  [0:CAPACITY-1];
    shift_t           shift_cmd;
    shift_t           shift_reg, shift_next;
    res_t             hold_reg, hold_next;
    res_t             out_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             exit_valid;
    logic             hold_load;
    logic             out_load;
    logic             sel_load;
    logic [IDX_W-1:0] sel_new;
    pkt_t             pe;

    assign accept     = in_valid && in_ready;
    assign pe         = pkt_chain[CAPACITY];
    assign exit_valid = pe.valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (exit_valid)
                begin
                    state_next = shift_next.valid ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        in_ready        = 1'b0;
        hold_load       = 1'b0;
        shift_cmd.valid = 1'b0;
        shift_cmd.k     = shift_reg.k;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready        = 1'b1;
            ST_WALK:  hold_load       = exit_valid;
            ST_SHIFT: shift_cmd.valid = 1'b1;
            ST_DONE:  out_load        = !out_valid_reg || out_ready;
            default:  in_ready        = 1'b0;
        endcase
    end

    // operation word built from the accepted input
    always_comb
    begin
        launch_next        = '0;
        launch_next.valid  = accept;
        launch_next.kind   = kind_t'(kind);
        launch_next.id     = entry_id;
        launch_next.date   = due_date;
        launch_next.time_s = due_time;
        launch_next.dose   = {remaining_quantity, storage_slot, doses_per_day, units_per_dose};
        launch_next.cnt    = count_reg;
        launch_next.sel    = (CNT_W'(sel_reg) >= count_reg) ? '0 : sel_reg;
        case (kind_t'(kind))
            KIND_ADD:  launch_next.act = count_reg < CAP_CNT;
            KIND_FIND: launch_next.act = count_reg != '0;
            default:   launch_next.act = 1'b1;
        endcase
    end

    assign pkt_chain[0] = launch_reg;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i + 1 < CAPACITY)
        begin : g_nxt
            assign nxt_ents[i] = ents[i+1];
        end
        else
        begin : g_last
            assign nxt_ents[i] = '0;
        end
        edet_cell #(
            .CELL_IDX (i),
            .CAPACITY (CAPACITY)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .pkt_in    (pkt_chain[i]),
            .shift_cmd (shift_cmd),
            .nxt_entry (nxt_ents[i]),
            .entry     (ents[i]),
            .pkt_out   (pkt_chain[i+1])
        );
    end

    // result from the word leaving the last cell
    always_comb
    begin
        hold_next        = '0;
        hold_next.status = STAT_OK;
        hold_next.cnt    = pe.cnt;
        shift_next       = '0;
        shift_next.k     = pe.k;
        sel_load         = 1'b0;
        sel_new          = pe.best_idx;
        case (pe.kind)
            KIND_ADD:
            begin
                if (pe.act)
                begin
                    hold_next.cnt = pe.cnt + CNT_W'(1);
                end
                else
                begin
                    hold_next.status = STAT_FULL;
                end
            end
            KIND_DELETE:
            begin
                if (pe.found)
                begin
                    hold_next.cnt    = pe.cnt - CNT_W'(1);
                    shift_next.valid = exit_valid;
                end
                else
                begin
                    hold_next.status = STAT_NOT_FOUND;
                end
            end
            KIND_UPDATE:
            begin
                if (!pe.found)
                begin
                    hold_next.status = STAT_NOT_FOUND;
                end
            end
            KIND_FIND:
            begin
                if (pe.act)
                begin
                    sel_load = 1'b1;
                    // the earlier selection survives a tie with the minimum
                    if ({pe.sel_date, pe.sel_time} == {pe.best_date, pe.best_time})
                    begin
                        sel_new        = pe.sel;
                        hold_next.idx  = pe.sel;
                        hold_next.id   = pe.sel_id;
                        hold_next.slot = pe.sel_slot;
                    end
                    else
                    begin
                        hold_next.idx  = pe.best_idx;
                        hold_next.id   = pe.best_id;
                        hold_next.slot = pe.best_slot;
                    end
                end
                else
                begin
                    hold_next.status = STAT_EMPTY;
                end
            end
            default:
            begin
                hold_next.status = STAT_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sel_reg       <= '0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                launch_reg <= launch_next;
            end
            else
            begin
                launch_reg.valid <= 1'b0;
            end
            if (hold_load)
            begin
                count_reg <= hold_next.cnt;
                if (sel_load)
                begin
                    sel_reg <= sel_new;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (hold_load)
        begin
            hold_reg  <= hold_next;
            shift_reg <= shift_next;
        end
        if (out_load)
        begin
            out_reg <= hold_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign entry_count    = out_reg.cnt[3:0];
    assign earliest_index = out_reg.idx[2:0];
    assign earliest_id    = out_reg.id;
    assign earliest_slot  = out_reg.slot;

endmodule

@@ rtl/edet_checker.sv @@
// port-level checks for the earliest-due entry table, bound to the top level
`timescale 1ns / 1ps

module edet_checker
    import edet_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  kind,
    input logic [15:0] entry_id,
    input logic [30:0] due_date,
    input logic [16:0] due_time,
    input logic [15:0] remaining_quantity,
    input logic [3:0]  storage_slot,
    input logic [3:0]  doses_per_day,
    input logic [3:0]  units_per_dose,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [3:0]  entry_count,
    input logic [2:0]  earliest_index,
    input logic [15:0] earliest_id,
    input logic [3:0]  earliest_slot
);

    localparam logic [3:0] CAP4 = 4'(CAPACITY);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(entry_count) && $stable(earliest_id) && $stable(earliest_slot))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while a word is in flight");

    // a full report only when the table holds capacity entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> entry_count == CAP4)
        else $error("table full reported with spare room");

    // an empty report carries no entry
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |->
        entry_count == 4'd0 && earliest_id == 16'd0 && earliest_index == 3'd0)
        else $error("empty table reported with contents");

endmodule

bind earliest_due_entry_table_top edet_checker #(.CAPACITY(CAPACITY)) u_edet_checker (.*);
